// ===== sv/bmhq_pkg.sv =====
// Shared constants and codes for the binary min-heap queue.
`default_nettype none

package bmhq_pkg;

	// default geometry
	localparam int CAPACITY_DEF  = 64;
	localparam int KEY_WIDTH_DEF = 32;

	// operation selector carried on s_tuser
	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// result status code
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

`default_nettype wire

// ===== sv/binary_min_heap_queue_core.sv =====
// Binary min-heap priority queue: sequencer, heap store and result register.
//
// Usage: each word on the s_ side is one operation. s_tuser selects it (0 push,
// 1 pop) and s_tdata carries the key for a push. Every operation returns exactly
// one word on the m_ side: the smallest key held afterwards (0 when empty), the
// entry count, an empty flag and a status (ok, push refused as full, pop refused
// as empty). A refused operation leaves the store untouched.
// Refused operations and a pop that empties the queue go straight to the result
// state; other operations first sift through the single-port store. s_tready is
// high only while the sequencer is idle, so the next word is taken only after
// the result is loaded.
// Reset: arst_n clears the entry count and the control state; the heap store
// itself is not cleared, only entries below the count are ever read.
// Stall: the result sits in an output register. A new operation may be taken
// while it waits; that operation then holds its own result until the old one
// has been taken, and no further word is accepted meanwhile.
`default_nettype none

module binary_min_heap_queue_core #(
	parameter int CAPACITY  = bmhq_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	// input channel
	input  wire logic s_tvalid,
	output logic      s_tready,
	// s_tdata: value (KEY_WIDTH bits), zero padding up to a whole byte
	input  wire logic [((KEY_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
	// s_tuser: action (1 bit), 0 push, 1 pop
	input  wire logic s_tuser,
	// result channel
	output logic      m_tvalid,
	input  wire logic m_tready,
	// m_tdata: top_value (KEY_WIDTH), entry_count (clog2(CAPACITY+1)), is_empty (1),
	//          status (2), zero padding up to a whole byte
	output logic [((KEY_WIDTH + $clog2(CAPACITY + 1) + 3 + 7) / 8) * 8 - 1:0] m_tdata
);

	localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1; // store address
	localparam int CW  = $clog2(CAPACITY + 1);                   // entry count
	localparam int IW  = AW + 2;                                 // child index
	localparam int MDW = ((KEY_WIDTH + CW + 3 + 7) / 8) * 8;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHK,   // sift up: fetch parent or settle at root
		S_UP_CMP,   // sift up: compare parent with key
		S_POP_LD,   // pop: last entry arrives as the new key
		S_DN_CHK,   // sift down: fetch left child or settle at leaf
		S_DN_L,     // sift down: left child arrives, fetch right or decide
		S_DN_R,     // sift down: right child arrives, decide
		S_FIN       // hand result to the output register
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     pos_q;      // current hole position
	logic [KEY_WIDTH-1:0] key_q;   // key being sifted
	logic [KEY_WIDTH-1:0] lval_q;  // left child during sift down
	logic [KEY_WIDTH-1:0] top_q;   // shadow of store entry 0
	bmhq_pkg::status_t status_q;
	logic              m_tvalid_q;
	logic [MDW-1:0]    m_tdata_q;

	// heap store, single port
	logic [KEY_WIDTH-1:0] mem [CAPACITY];
	logic [KEY_WIDTH-1:0] rdata_q;
	logic                 re, we;
	logic [AW-1:0]        raddr, waddr;
	logic [KEY_WIDTH-1:0] wdata;

	logic                 s_accept;
	logic                 act_pop;
	logic [KEY_WIDTH-1:0] in_key;
	logic [AW-1:0]        parent;
	logic [IW-1:0]        l_idx, r_idx, count_x;
	logic                 l_in, r_in;
	logic                 up_move, left_move, take_r, take_l;
	logic                 out_free;
	logic [KEY_WIDTH-1:0] top_out;

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign act_pop  = (s_tuser == bmhq_pkg::ACT_POP);
	assign in_key   = s_tdata[KEY_WIDTH-1:0];

	// index arithmetic around the hole
	assign parent  = (pos_q - AW'(1)) >> 1;
	assign l_idx   = {1'b0, pos_q, 1'b1};
	assign r_idx   = l_idx + IW'(1);
	assign count_x = IW'(count_q);
	assign l_in    = (l_idx < count_x);
	assign r_in    = (r_idx < count_x);

	// comparators per state, against the registered read word and the held left child
	assign up_move   = (rdata_q > key_q);
	assign left_move = (rdata_q < key_q);
	assign take_r    = (rdata_q < lval_q) && (rdata_q < key_q);
	assign take_l    = !take_r && (lval_q < key_q);

	assign out_free = !m_tvalid_q || m_tready;
	assign top_out  = (count_q == '0) ? '0 : top_q;

	// store port control
	always_comb begin
		re    = 1'b0;
		raddr = '0;
		we    = 1'b0;
		waddr = pos_q;
		wdata = key_q;
		case (state_q)
			S_IDLE: begin
				// pop with more than one entry: fetch the last one
				if (s_accept && act_pop && (count_q > CW'(1))) begin
					re    = 1'b1;
					raddr = AW'(count_q - CW'(1));
				end
			end
			S_UP_CHK: begin
				if (pos_q == '0) begin
					we = 1'b1;
				end else begin
					re    = 1'b1;
					raddr = parent;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (up_move) begin
					wdata = rdata_q;
				end
			end
			S_DN_CHK: begin
				if (l_in) begin
					re    = 1'b1;
					raddr = l_idx[AW-1:0];
				end else begin
					we = 1'b1;
				end
			end
			S_DN_L: begin
				if (r_in) begin
					re    = 1'b1;
					raddr = r_idx[AW-1:0];
				end else begin
					we = 1'b1;
					if (left_move) begin
						wdata = rdata_q;
					end
				end
			end
			S_DN_R: begin
				we = 1'b1;
				if (take_r) begin
					wdata = rdata_q;
				end else if (take_l) begin
					wdata = lval_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			pos_q      <= '0;
			key_q      <= '0;
			lval_q     <= '0;
			top_q      <= '0;
			status_q   <= bmhq_pkg::ST_OK;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			// result loaded once the register is free, else dropped when taken
			if ((state_q == S_FIN) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// any write to the root also refreshes the top shadow
			if (we && (waddr == '0)) begin
				top_q <= wdata;
			end
			case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						if (!act_pop) begin
							if (count_q == CW'(CAPACITY)) begin
								status_q <= bmhq_pkg::ST_FULL;
								state_q  <= S_FIN;
							end else begin
								status_q <= bmhq_pkg::ST_OK;
								key_q    <= in_key;
								pos_q    <= AW'(count_q);
								count_q  <= count_q + CW'(1);
								state_q  <= S_UP_CHK;
							end
						end else begin
							if (count_q == '0) begin
								status_q <= bmhq_pkg::ST_EMPTY;
								state_q  <= S_FIN;
							end else begin
								status_q <= bmhq_pkg::ST_OK;
								count_q  <= count_q - CW'(1);
								state_q  <= (count_q == CW'(1)) ? S_FIN : S_POP_LD;
							end
						end
					end
				end
				S_UP_CHK: begin
					state_q <= (pos_q == '0) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_move) begin
						pos_q   <= parent;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_POP_LD: begin
					key_q   <= rdata_q;
					pos_q   <= '0;
					state_q <= S_DN_CHK;
				end
				S_DN_CHK: begin
					state_q <= l_in ? S_DN_L : S_FIN;
				end
				S_DN_L: begin
					lval_q <= rdata_q;
					if (r_in) begin
						state_q <= S_DN_R;
					end else if (left_move) begin
						pos_q   <= l_idx[AW-1:0];
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_DN_R: begin
					if (take_r) begin
						pos_q   <= r_idx[AW-1:0];
						state_q <= S_DN_CHK;
					end else if (take_l) begin
						pos_q   <= l_idx[AW-1:0];
						state_q <= S_DN_CHK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					// wait here while the previous result is still unclaimed
					if (out_free) begin
						m_tdata_q  <= MDW'({status_q, (count_q == '0), count_q, top_out});
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// entry count never goes beyond the store
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count beyond capacity");

	// a refused push leaves the count alone and reports full
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !act_pop && (count_q == CW'(CAPACITY)))
		|=> (count_q == CW'(CAPACITY)) && (status_q == bmhq_pkg::ST_FULL))
		else $error("push on full store altered state");

	// a refused pop leaves the count at zero and reports empty
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && act_pop && (count_q == '0))
		|=> (count_q == '0) && (status_q == bmhq_pkg::ST_EMPTY))
		else $error("pop on empty store altered state");

	// the hole lies inside the occupied part of the store whenever a sift step checks it
	a_hole_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_UP_CHK) || (state_q == S_DN_CHK)) |-> (CW'(pos_q) < count_q))
		else $error("sift position outside occupied entries");

	// the empty flag of a result agrees with its entry count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (m_tdata_q[KEY_WIDTH+CW] == (m_tdata_q[KEY_WIDTH+CW-1:KEY_WIDTH] == '0)))
		else $error("empty flag disagrees with entry count");

endmodule

`default_nettype wire

// ===== tb/sv/binary_min_heap_queue_core_tb.sv =====
// Self-checking bench for the binary min-heap queue core: directed table, then random bursts.
`default_nettype none

module binary_min_heap_queue_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// geometry of the instance under test (package defaults)
	localparam int CAP      = bmhq_pkg::CAPACITY_DEF;
	localparam int KW       = bmhq_pkg::KEY_WIDTH_DEF;
	localparam int CW       = $clog2(CAP + 1);
	localparam int SW       = ((KW + 7) / 8) * 8;
	localparam int MW       = ((KW + CW + 3 + 7) / 8) * 8;
	// result word layout, lowest bit up
	localparam int CNT_LO   = KW;
	localparam int EMPTY_B  = KW + CW;
	localparam int ST_LO    = KW + CW + 1;

	localparam int RANDOM_OPS  = 900;
	localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off in the last phase
	localparam int DRAIN_WAIT  = 40;    // extra wait for stray result words

	// one result word, split into its fields
	typedef struct {
		logic [KW-1:0]     top_value;
		logic [CW-1:0]     entry_count;
		logic              is_empty;
		bmhq_pkg::status_t status;
	} heap_word_t;

	// one row of the directed table
	typedef struct {
		logic          action;
		logic [KW-1:0] value;
		bit            typed;   // expectation typed in rather than predicted
		heap_word_t    word;
	} heap_cmd_t;

	logic          clk      = 1'b0;
	logic          arst_n   = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [SW-1:0] s_tdata  = '0;
	logic          s_tuser  = bmhq_pkg::ACT_PUSH;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [MW-1:0] m_tdata;

	// predictor state: heap image and entry count
	logic [KW-1:0] heap_keys [CAP];
	int            heap_count;

	heap_word_t    expected_words [$];
	heap_cmd_t     directed_ops [$];
	int            fail_count = 0;
	int            load_phase = 0;   // 0: receiver sparse, 1: sender sparse idling, 2: none
	int            stall_cycles = 0;

	binary_min_heap_queue_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor: apply one operation to the heap image and form the result word.
	// Push appends and climbs while the parent is strictly greater; pop moves the
	// last key to the root and sinks it, right child only when strictly smaller
	// than the left one, so equal children send it left.
	function automatic heap_word_t heap_apply(input logic action, input logic [KW-1:0] value);
		heap_word_t    w;
		int            pos;
		int            up;
		int            lc;
		int            rc;
		bit            settled;
		logic [KW-1:0] tmp;
		w.status = bmhq_pkg::ST_OK;
		if (action == bmhq_pkg::ACT_PUSH) begin
			if (heap_count >= CAP) begin
				w.status = bmhq_pkg::ST_FULL;
			end else begin
				heap_keys[heap_count] = value;
				pos = heap_count;
				heap_count++;
				settled = 1'b0;
				while (pos > 0 && !settled) begin
					up = (pos - 1) / 2;
					if (heap_keys[up] > heap_keys[pos]) begin
						tmp = heap_keys[up];
						heap_keys[up] = heap_keys[pos];
						heap_keys[pos] = tmp;
						pos = up;
					end else begin
						settled = 1'b1;
					end
				end
			end
		end else begin
			if (heap_count == 0) begin
				w.status = bmhq_pkg::ST_EMPTY;
			end else begin
				heap_count--;
				heap_keys[0] = heap_keys[heap_count];
				pos = 0;
				settled = 1'b0;
				while (2 * pos + 1 < heap_count && !settled) begin
					lc = 2 * pos + 1;
					rc = lc + 1;
					if (rc < heap_count && heap_keys[rc] < heap_keys[lc]
							&& heap_keys[rc] < heap_keys[pos]) begin
						tmp = heap_keys[rc];
						heap_keys[rc] = heap_keys[pos];
						heap_keys[pos] = tmp;
						pos = rc;
					end else if (heap_keys[lc] < heap_keys[pos]) begin
						tmp = heap_keys[lc];
						heap_keys[lc] = heap_keys[pos];
						heap_keys[pos] = tmp;
						pos = lc;
					end else begin
						settled = 1'b1;
					end
				end
			end
		end
		w.top_value   = (heap_count > 0) ? heap_keys[0] : '0;
		w.entry_count = CW'(heap_count);
		w.is_empty    = (heap_count == 0);
		return w;
	endfunction

	// append one row to the directed table
	task automatic add_row(input logic action, input logic [KW-1:0] value,
			input bit typed, input logic [KW-1:0] top, input int cnt, input logic emp,
			input bmhq_pkg::status_t st);
		heap_cmd_t c;
		c.action           = action;
		c.value            = value;
		c.typed            = typed;
		c.word.top_value   = top;
		c.word.entry_count = CW'(cnt);
		c.word.is_empty    = emp;
		c.word.status      = st;
		directed_ops.insert(directed_ops.size(), c);
	endtask

	// keys biased towards the extremes and a narrow band, so duplicates are common
	function automatic logic [KW-1:0] pick_key();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2, 3, 4: return KW'($urandom_range(0, 15));
			default: return KW'($urandom);
		endcase
	endfunction

	// Offer one operation, hold it until taken, then log what it should return.
	// The sender only idles before raising tvalid, so tvalid never drops and
	// rises within the same step.
	task automatic offer_op(input heap_cmd_t c);
		heap_word_t w;
		int         idle_pct;
		idle_pct = (load_phase == 0) ? 14 : (load_phase == 1) ? 71 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c.action;
		s_tdata  <= SW'(c.value);
		do @(posedge clk); while (!s_tready);
		w = heap_apply(c.action, c.value);
		expected_words.insert(expected_words.size(), c.typed ? c.word : w);
	endtask

	task automatic check_field(input string field, input logic [KW-1:0] exp_v,
			input logic [KW-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v,
				act_v);
			fail_count++;
		end
	endtask

	// Receiver: random tready by phase, plus one long hold-off at the start of the
	// last phase so the core fills its output register and blocks s_tready.
	initial begin : receiver
		int  hold_left;
		bit  held;
		int  idle_pct;
		hold_left = 0;
		held      = 1'b0;
		forever begin
			@(posedge clk);
			idle_pct = (load_phase == 0) ? 71 : (load_phase == 1) ? 14 : 0;
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else if (load_phase == 2 && !held) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
				m_tready  <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	// Result checker: every word taken is compared against the oldest expectation.
	always @(posedge clk) begin
		heap_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				$display("%0t ns: result word with nothing expected, expected none, got 0x%0h",
					$time, m_tdata);
				fail_count++;
			end else begin
				w = expected_words.pop_front();
				check_field("top_value", w.top_value, m_tdata[KW-1:0]);
				check_field("entry_count", KW'(w.entry_count), KW'(m_tdata[CNT_LO +: CW]));
				check_field("is_empty", KW'(w.is_empty), KW'(m_tdata[EMPTY_B]));
				check_field("status", KW'(w.status), KW'(m_tdata[ST_LO +: 2]));
			end
		end
	end

	// Watchdog: a long run of cycles with no word moving on either side is a hang.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("binary_min_heap_queue_core test failed");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int        sent;
		int        burst_len;
		int        mode;
		int        push_pct;
		heap_cmd_t c;

		// Directed table. Typed rows: empty queue after reset, the key extremes,
		// and the empty refusal code. The rest (duplicates, equal children on the way
		// down, alternating bit patterns) goes to the predictor.
		add_row(bmhq_pkg::ACT_POP,  32'h1234_5678, 1'b1, 32'h0, 0, 1'b1, bmhq_pkg::ST_EMPTY);
		add_row(bmhq_pkg::ACT_PUSH, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1, 1'b0,
			bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_PUSH, 32'h0000_0000, 1'b1, 32'h0, 2, 1'b0, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_POP,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1, 1'b0,
			bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_POP,  32'h0000_0000, 1'b1, 32'h0, 0, 1'b1, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_POP,  32'hA5A5_A5A5, 1'b1, 32'h0, 0, 1'b1, bmhq_pkg::ST_EMPTY);
		add_row(bmhq_pkg::ACT_PUSH, 32'h8000_0000, 1'b1, 32'h8000_0000, 1, 1'b0,
			bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_PUSH, 32'h0000_0007, 1'b0, '0, 0, 1'b0, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_PUSH, 32'h0000_0007, 1'b0, '0, 0, 1'b0, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_PUSH, 32'h0000_0007, 1'b0, '0, 0, 1'b0, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_PUSH, 32'h0000_0007, 1'b0, '0, 0, 1'b0, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_PUSH, 32'h0000_0003, 1'b0, '0, 0, 1'b0, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_PUSH, 32'h7FFF_FFFF, 1'b0, '0, 0, 1'b0, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_PUSH, 32'h5555_5555, 1'b0, '0, 0, 1'b0, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_PUSH, 32'hAAAA_AAAA, 1'b0, '0, 0, 1'b0, bmhq_pkg::ST_OK);
		repeat (8) add_row(bmhq_pkg::ACT_POP, 32'hFFFF_FFFF, 1'b0, '0, 0, 1'b0,
			bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_POP,  32'h0000_0000, 1'b1, 32'h0, 0, 1'b1, bmhq_pkg::ST_OK);
		add_row(bmhq_pkg::ACT_POP,  32'h0000_0000, 1'b1, 32'h0, 0, 1'b1, bmhq_pkg::ST_EMPTY);

		heap_count = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_ops[i]) offer_op(directed_ops[i]);

		// Random part in bursts: fill runs that overrun capacity (full refusals),
		// drain runs that overrun empty (empty refusals), and mixed traffic.
		sent = 0;
		while (sent < RANDOM_OPS) begin
			load_phase = (sent * 3) / RANDOM_OPS;
			mode = $urandom_range(0, 2);
			case (mode)
				0: begin burst_len = $urandom_range(20, 80); push_pct = 90; end
				1: begin burst_len = $urandom_range(20, 80); push_pct = 10; end
				default: begin burst_len = $urandom_range(10, 40); push_pct = 50; end
			endcase
			repeat (burst_len) begin
				c.action = ($urandom_range(0, 99) < push_pct) ? bmhq_pkg::ACT_PUSH
					: bmhq_pkg::ACT_POP;
				c.value  = pick_key();
				c.typed  = 1'b0;
				offer_op(c);
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0) begin
			$display("binary_min_heap_queue_core test passed");
		end else begin
			$display("binary_min_heap_queue_core test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/bmhq_pkg.sv
sv/binary_min_heap_queue_core.sv
tb/sv/binary_min_heap_queue_core_tb.sv
